### hdl/alu3_pkg.sv
// ----------------------------------------------------------------------------
// alu3_pkg
// Opcodes, item types and constants of the group-3 integer execution unit.
// ----------------------------------------------------------------------------
package alu3_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned MACLEN = 2 * XLEN;
  localparam logic [XLEN-1:0] SIGN_BIT = 32'h8000_0000;

  // low nibble of the group-3 opcode; codes 1 and 9 are not implemented
  typedef enum logic [3:0] {
    OP_CMP_EQ = 4'd0,
    OP_CMP_HS = 4'd2,
    OP_CMP_GE = 4'd3,
    OP_DIV1   = 4'd4,
    OP_DMULU  = 4'd5,
    OP_CMP_HI = 4'd6,
    OP_CMP_GT = 4'd7,
    OP_SUB    = 4'd8,
    OP_SUBC   = 4'd10,
    OP_SUBV   = 4'd11,
    OP_ADD    = 4'd12,
    OP_DMULS  = 4'd13,
    OP_ADDC   = 4'd14,
    OP_ADDV   = 4'd15
  } alu3_op_t;

  typedef struct packed {
    logic [3:0]      mode;
    logic [XLEN-1:0] rn_value;
    logic [XLEN-1:0] rm_value;
    logic            t_in;
    logic            q_in;
    logic            m_in;
  } alu3_req_t;

  typedef struct packed {
    logic [XLEN-1:0]   rn_result;
    logic              rn_write;
    logic              t_out;
    logic              q_out;
    logic [MACLEN-1:0] mac_result;
    logic              mac_write;
    logic              illegal;
  } alu3_res_t;

endpackage

### hdl/alu3_if.sv
// ----------------------------------------------------------------------------
// alu3_if
// Valid/ready channels of the group-3 execution unit: instruction in, result out.
// ----------------------------------------------------------------------------
interface alu3_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] rn_value;
  logic [31:0] rm_value;
  logic        t_in;
  logic        q_in;
  logic        m_in;

  modport source (output valid, mode, rn_value, rm_value, t_in, q_in, m_in, input ready);
  modport sink   (input valid, mode, rn_value, rm_value, t_in, q_in, m_in, output ready);
endinterface

interface alu3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rn_result;
  logic        rn_write;
  logic        t_out;
  logic        q_out;
  logic [63:0] mac_result;
  logic        mac_write;
  logic        illegal;

  modport source (output valid, rn_result, rn_write, t_out, q_out, mac_result, mac_write,
                  illegal, input ready);
  modport sink   (input valid, rn_result, rn_write, t_out, q_out, mac_result, mac_write,
                  illegal, output ready);
endinterface

### hdl/alu3_exec.sv
// ----------------------------------------------------------------------------
// alu3_exec
// Single-pass datapath: compares, divide step, add/sub forms and 33x33 multiply.
// ----------------------------------------------------------------------------
module alu3_exec
  import alu3_pkg::*;
(
  input  alu3_req_t req,
  output alu3_res_t res
);

  logic [XLEN-1:0]     rn;
  logic [XLEN-1:0]     rm;
  logic [XLEN-1:0]     div_sh;
  logic [XLEN:0]       div_sum;
  logic [XLEN:0]       sub_w;
  logic [XLEN:0]       add_w;
  logic [XLEN:0]       subc_w;
  logic [XLEN:0]       addc_w;
  logic                div_q;
  logic                mul_sx;
  logic signed [XLEN:0]     mul_a;
  logic signed [XLEN:0]     mul_b;
  logic signed [2*XLEN+1:0] mul_p;

  assign rn = req.rn_value;
  assign rm = req.rm_value;

  // divide step: shift T in, subtract when Q equals M, else add
  assign div_sh  = {rn[XLEN-2:0], req.t_in};
  assign div_sum = (req.q_in == req.m_in) ? ({1'b0, div_sh} - {1'b0, rm})
                                          : ({1'b0, div_sh} + {1'b0, rm});
  assign div_q   = rn[XLEN-1] ^ div_sum[XLEN] ^ req.m_in;

  // top bit of each 33-bit result is the carry or borrow
  assign sub_w  = {1'b0, rn} - {1'b0, rm};
  assign add_w  = {1'b0, rn} + {1'b0, rm};
  assign subc_w = {1'b0, rn} - {1'b0, rm} - {{XLEN{1'b0}}, req.t_in};
  assign addc_w = {1'b0, rn} + {1'b0, rm} + {{XLEN{1'b0}}, req.t_in};

  // one signed 33x33 multiplier serves both dmulu and dmuls
  assign mul_sx = (req.mode == OP_DMULS);
  assign mul_a  = signed'({mul_sx & rn[XLEN-1], rn});
  assign mul_b  = signed'({mul_sx & rm[XLEN-1], rm});
  assign mul_p  = mul_a * mul_b;

  always_comb begin
    res.rn_result  = rn;
    res.rn_write   = 1'b0;
    res.t_out      = req.t_in;
    res.q_out      = req.q_in;
    res.mac_result = '0;
    res.mac_write  = 1'b0;
    res.illegal    = 1'b0;
    unique case (req.mode) inside
      OP_CMP_EQ: res.t_out = (rn == rm);
      OP_CMP_HS: res.t_out = (rn >= rm);
      OP_CMP_GE: res.t_out = ((rn ^ SIGN_BIT) >= (rm ^ SIGN_BIT));
      OP_CMP_HI: res.t_out = (rn > rm);
      OP_CMP_GT: res.t_out = ((rn ^ SIGN_BIT) > (rm ^ SIGN_BIT));
      OP_DIV1: begin
        res.rn_result = div_sum[XLEN-1:0];
        res.rn_write  = 1'b1;
        res.q_out     = div_q;
        res.t_out     = (div_q == req.m_in);
      end
      OP_DMULU, OP_DMULS: begin
        res.mac_result = mul_p[MACLEN-1:0];
        res.mac_write  = 1'b1;
      end
      OP_SUB: begin
        res.rn_result = sub_w[XLEN-1:0];
        res.rn_write  = 1'b1;
      end
      OP_ADD: begin
        res.rn_result = add_w[XLEN-1:0];
        res.rn_write  = 1'b1;
      end
      OP_SUBC: begin
        res.rn_result = subc_w[XLEN-1:0];
        res.rn_write  = 1'b1;
        res.t_out     = subc_w[XLEN];
      end
      OP_ADDC: begin
        res.rn_result = addc_w[XLEN-1:0];
        res.rn_write  = 1'b1;
        res.t_out     = addc_w[XLEN];
      end
      OP_SUBV: begin
        res.rn_result = sub_w[XLEN-1:0];
        res.rn_write  = 1'b1;
        res.t_out     = (rn[XLEN-1] ^ rm[XLEN-1]) & (rn[XLEN-1] ^ sub_w[XLEN-1]);
      end
      OP_ADDV: begin
        res.rn_result = add_w[XLEN-1:0];
        res.rn_write  = 1'b1;
        res.t_out     = ~(rn[XLEN-1] ^ rm[XLEN-1]) & (rn[XLEN-1] ^ add_w[XLEN-1]);
      end
      default: res.illegal = 1'b1;
    endcase
  end

endmodule

### hdl/cpu_alu_compare_divstep_multiply_unit.sv
// ----------------------------------------------------------------------------
// cpu_alu_compare_divstep_multiply_unit
// Group-3 integer execution unit: compares, div1, dmulu/dmuls, add/sub forms.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one instruction per item: opcode low nibble, Rn and Rm
//   values and the T, Q and M flags. out_ch carries one result per item:
//   new Rn with its write enable, new T and Q, the 64-bit MAC product with
//   its write enable, and the illegal flag for codes 1 and 9.
//   Both channels use valid/ready; an item moves when both are high.
//   The item is registered in the input stage, goes through one pass of
//   the datapath (the 33x33 multiplier sets the path) and lands in the
//   result register, which drives out_ch.valid.
//   Throughput is one item per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input
//   register can still take one more item; in_ch.ready then drops until
//   out_ch.ready returns.
//   Reset (rst_n low, synchronous) empties both stages; no result is lost
//   or repeated across a stall.
// ----------------------------------------------------------------------------
module cpu_alu_compare_divstep_multiply_unit
  import alu3_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  alu3_in_if.sink    in_ch,
  alu3_out_if.source out_ch
);

  logic      s1_vld_r;
  logic      s1_vld_nxt;
  alu3_req_t s1_req_r;
  logic      out_vld_r;
  logic      out_vld_nxt;
  alu3_res_t out_res_r;
  alu3_res_t exec_res;
  alu3_req_t in_req;
  logic      in_fire;
  logic      out_adv;

  assign in_req.mode     = in_ch.mode;
  assign in_req.rn_value = in_ch.rn_value;
  assign in_req.rm_value = in_ch.rm_value;
  assign in_req.t_in     = in_ch.t_in;
  assign in_req.q_in     = in_ch.q_in;
  assign in_req.m_in     = in_ch.m_in;

  // result register can load when empty or being drained
  assign out_adv     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !s1_vld_r || out_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign s1_vld_nxt  = in_fire ? 1'b1 : (out_adv ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;

  alu3_exec u_exec (
    .req (s1_req_r),
    .res (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req;
    end
    if (out_adv && s1_vld_r) begin
      out_res_r <= exec_res;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.rn_result  = out_res_r.rn_result;
  assign out_ch.rn_write   = out_res_r.rn_write;
  assign out_ch.t_out      = out_res_r.t_out;
  assign out_ch.q_out      = out_res_r.q_out;
  assign out_ch.mac_result = out_res_r.mac_result;
  assign out_ch.mac_write  = out_res_r.mac_write;
  assign out_ch.illegal    = out_res_r.illegal;

  // an item in the input stage moves into the result register when it can
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_adv) |=> out_vld_r)
    else $error("item in input stage not forwarded");

  // a stalled item in the input stage is neither lost nor replaced
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_adv) |=> (s1_vld_r && $stable(s1_req_r)))
    else $error("stalled input stage item changed");

  // an item never writes both Rn and MAC
  a_one_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_res_r.rn_write && out_res_r.mac_write))
    else $error("result writes both rn and mac");

  // illegal codes change nothing
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.illegal) |->
      (!out_res_r.rn_write && !out_res_r.mac_write && out_res_r.mac_result == '0))
    else $error("illegal item has side effects");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !s1_vld_r))
    else $error("pipeline not empty after reset");

endmodule

### bench/tb_cpu_alu_compare_divstep_multiply_unit.sv
// ----------------------------------------------------------------------------
// tb_cpu_alu_compare_divstep_multiply_unit
// Self-checking bench for the group-3 integer execution unit. A directed set
// covers every opcode and its corner operands. Random phases follow with
// chained div1 sequences and carry/borrow chains, while both channel sides
// idle and stall at different rates. Every accepted instruction is run
// through a local model of the unit, and each result is compared against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_cpu_alu_compare_divstep_multiply_unit;
  import alu3_pkg::*;

  localparam logic [3:0] OP_UNIMPL_1 = 4'd1;
  localparam logic [3:0] OP_UNIMPL_9 = 4'd9;
  localparam int STUCK_LIMIT = 2000;
  localparam int PHASE_ITEMS = 312;

  logic clk;
  logic rst_n;

  alu3_in_if  in_ch();
  alu3_out_if out_ch();

  cpu_alu_compare_divstep_multiply_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu3_req_t pending_instrs[$];
  alu3_res_t expected_results[$];
  int        instrs_queued;
  int        instrs_taken;
  int        mismatches;
  int        stuck_cycles;
  int        idle_pct;
  int        stall_pct;
  bit        in_taken;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local model of one group-3 instruction
  function automatic alu3_res_t exec_group3(input alu3_req_t r);
    alu3_res_t   e;
    logic [32:0] wide;
    logic [31:0] shifted;
    logic [63:0] a64;
    logic [63:0] b64;
    e.rn_result  = r.rn_value;
    e.rn_write   = 1'b0;
    e.t_out      = r.t_in;
    e.q_out      = r.q_in;
    e.mac_result = '0;
    e.mac_write  = 1'b0;
    e.illegal    = 1'b0;
    case (r.mode)
      OP_CMP_EQ: e.t_out = (r.rn_value == r.rm_value);
      OP_CMP_HS: e.t_out = (r.rn_value >= r.rm_value);
      OP_CMP_HI: e.t_out = (r.rn_value > r.rm_value);
      OP_CMP_GE: e.t_out = ((r.rn_value ^ SIGN_BIT) >= (r.rm_value ^ SIGN_BIT));
      OP_CMP_GT: e.t_out = ((r.rn_value ^ SIGN_BIT) > (r.rm_value ^ SIGN_BIT));
      OP_DIV1: begin
        shifted = {r.rn_value[30:0], r.t_in};
        // bit 32 is the borrow of the subtract or the carry of the add
        if (r.q_in == r.m_in) begin
          wide = {1'b0, shifted} - {1'b0, r.rm_value};
        end else begin
          wide = {1'b0, shifted} + {1'b0, r.rm_value};
        end
        e.rn_result = wide[31:0];
        e.q_out     = r.rn_value[31] ^ wide[32] ^ r.m_in;
        e.t_out     = (e.q_out == r.m_in);
        e.rn_write  = 1'b1;
      end
      OP_DMULU: begin
        a64          = {32'b0, r.rn_value};
        b64          = {32'b0, r.rm_value};
        e.mac_result = a64 * b64;
        e.mac_write  = 1'b1;
      end
      OP_DMULS: begin
        // low 64 bits of the product of sign-extended operands
        a64          = {{32{r.rn_value[31]}}, r.rn_value};
        b64          = {{32{r.rm_value[31]}}, r.rm_value};
        e.mac_result = a64 * b64;
        e.mac_write  = 1'b1;
      end
      OP_SUB: begin
        e.rn_result = r.rn_value - r.rm_value;
        e.rn_write  = 1'b1;
      end
      OP_ADD: begin
        e.rn_result = r.rn_value + r.rm_value;
        e.rn_write  = 1'b1;
      end
      OP_SUBC: begin
        wide        = {1'b0, r.rn_value} - {1'b0, r.rm_value} - {32'b0, r.t_in};
        e.rn_result = wide[31:0];
        e.t_out     = wide[32];
        e.rn_write  = 1'b1;
      end
      OP_ADDC: begin
        wide        = {1'b0, r.rn_value} + {1'b0, r.rm_value} + {32'b0, r.t_in};
        e.rn_result = wide[31:0];
        e.t_out     = wide[32];
        e.rn_write  = 1'b1;
      end
      OP_SUBV: begin
        e.rn_result = r.rn_value - r.rm_value;
        e.t_out     = (r.rn_value[31] ^ r.rm_value[31]) & (r.rn_value[31] ^ e.rn_result[31]);
        e.rn_write  = 1'b1;
      end
      OP_ADDV: begin
        e.rn_result = r.rn_value + r.rm_value;
        e.t_out     = ~(r.rn_value[31] ^ r.rm_value[31]) & (r.rn_value[31] ^ e.rn_result[31]);
        e.rn_write  = 1'b1;
      end
      default: e.illegal = 1'b1;
    endcase
    return e;
  endfunction

  function automatic alu3_req_t make_instr(input logic [3:0] mode, input logic [31:0] rn,
                                           input logic [31:0] rm, input logic t,
                                           input logic q, input logic m);
    alu3_req_t r;
    r.mode     = mode;
    r.rn_value = rn;
    r.rm_value = rm;
    r.t_in     = t;
    r.q_in     = q;
    r.m_in     = m;
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    int          sel;
    logic [31:0] corners[7];
    corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001};
    sel = $urandom_range(99);
    if (sel < 50) return $urandom;
    if (sel < 70) return corners[$urandom_range(6)];
    if (sel < 85) return $urandom_range(255);
    return 32'hFFFF_FFFF - $urandom_range(255);
  endfunction

  task automatic queue_instr(input alu3_req_t r);
    pending_instrs.push_back(r);
    instrs_queued++;
  endtask

  task automatic queue_directed();
    queue_instr(make_instr(OP_CMP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
    queue_instr(make_instr(OP_CMP_EQ, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b1));
    queue_instr(make_instr(OP_CMP_HS, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1));
    queue_instr(make_instr(OP_CMP_HS, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 1'b0));
    queue_instr(make_instr(OP_CMP_GE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0));
    queue_instr(make_instr(OP_CMP_GE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    queue_instr(make_instr(OP_CMP_HI, 32'h1234_5678, 32'h1234_5678, 1'b1, 1'b0, 1'b0));
    queue_instr(make_instr(OP_CMP_GT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
    queue_instr(make_instr(OP_CMP_GT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
    // divide step: subtract with borrow, add with carry, both M values
    queue_instr(make_instr(OP_DIV1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
    queue_instr(make_instr(OP_DIV1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
    queue_instr(make_instr(OP_DIV1, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b1));
    queue_instr(make_instr(OP_DIV1, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b1));
    queue_instr(make_instr(OP_DMULU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    queue_instr(make_instr(OP_DMULS, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    queue_instr(make_instr(OP_DMULS, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 1'b1));
    queue_instr(make_instr(OP_SUB, 32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0, 1'b0));
    queue_instr(make_instr(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 1'b0));
    queue_instr(make_instr(OP_SUBC, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0));
    queue_instr(make_instr(OP_SUBC, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0));
    queue_instr(make_instr(OP_ADDC, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0));
    queue_instr(make_instr(OP_ADDC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    queue_instr(make_instr(OP_SUBV, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b0, 1'b0));
    queue_instr(make_instr(OP_ADDV, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 1'b0));
    queue_instr(make_instr(OP_UNIMPL_1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    queue_instr(make_instr(OP_UNIMPL_9, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic queue_random(input int count);
    int        made;
    int        sel;
    int        len;
    alu3_req_t r;
    alu3_res_t e;
    logic [3:0] chain_op;
    made = 0;
    while (made < count) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        // div1 chain as a real division runs it: flags set up as by div0s
        r = make_instr(OP_DIV1, pick_operand(), pick_operand(), 1'b0, 1'b0, 1'b0);
        if (r.rm_value == '0) r.rm_value = $urandom_range(1000, 1);
        r.q_in = r.rn_value[31];
        r.m_in = r.rm_value[31];
        r.t_in = r.q_in ^ r.m_in;
        len = $urandom_range(32, 8);
        repeat (len) begin
          queue_instr(r);
          e = exec_group3(r);
          r.rn_value = e.rn_result;
          r.t_in     = e.t_out;
          r.q_in     = e.q_out;
        end
        made += len;
      end else if (sel < 22) begin
        // multiword add or subtract, carry chained through T
        chain_op = ($urandom_range(1) == 0) ? OP_ADDC : OP_SUBC;
        r = make_instr(chain_op, pick_operand(), pick_operand(), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        len = $urandom_range(6, 2);
        repeat (len) begin
          queue_instr(r);
          e = exec_group3(r);
          r.t_in     = e.t_out;
          r.rn_value = pick_operand();
          r.rm_value = pick_operand();
        end
        made += len;
      end else begin
        r = make_instr(4'($urandom_range(15)), pick_operand(), pick_operand(),
                       1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        if ($urandom_range(99) < 15) r.rm_value = r.rn_value;
        queue_instr(r);
        made++;
      end
    end
  endtask

  task automatic drain();
    while (instrs_taken != instrs_queued || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_result(input alu3_res_t got);
    alu3_res_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: rn %h wr %b t %b q %b mac %h mw %b ill %b",
                 got.rn_result, got.rn_write, got.t_out, got.q_out, got.mac_result,
                 got.mac_write, got.illegal);
      end
    end else begin
      want = expected_results.pop_front();
      if (got.rn_result !== want.rn_result || got.rn_write !== want.rn_write ||
          got.t_out !== want.t_out || got.q_out !== want.q_out ||
          got.mac_result !== want.mac_result || got.mac_write !== want.mac_write ||
          got.illegal !== want.illegal) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch (exp/got): rn %h/%h wr %b/%b t %b/%b q %b/%b",
                   want.rn_result, got.rn_result, want.rn_write, got.rn_write,
                   want.t_out, got.t_out, want.q_out, got.q_out);
          $display("  mac %h/%h mw %b/%b ill %b/%b", want.mac_result, got.mac_result,
                   want.mac_write, got.mac_write, want.illegal, got.illegal);
        end
      end
    end
  endtask

  // driver: new item at the falling edge once the previous one was taken
  always @(negedge clk) begin
    alu3_req_t nxt;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pending_instrs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_instrs.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= nxt.mode;
        in_ch.rn_value <= nxt.rn_value;
        in_ch.rm_value <= nxt.rm_value;
        in_ch.t_in     <= nxt.t_in;
        in_ch.q_in     <= nxt.q_in;
        in_ch.m_in     <= nxt.m_in;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    alu3_res_t got;
    in_taken = 1'b0;
    if (rst_n) begin
      stuck_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        got.rn_result  = out_ch.rn_result;
        got.rn_write   = out_ch.rn_write;
        got.t_out      = out_ch.t_out;
        got.q_out      = out_ch.q_out;
        got.mac_result = out_ch.mac_result;
        got.mac_write  = out_ch.mac_write;
        got.illegal    = out_ch.illegal;
        check_result(got);
        stuck_cycles = 0;
      end
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        expected_results.push_back(exec_group3(make_instr(in_ch.mode, in_ch.rn_value,
                                   in_ch.rm_value, in_ch.t_in, in_ch.q_in, in_ch.m_in)));
        instrs_taken++;
        stuck_cycles = 0;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.rn_value = '0;
    in_ch.rm_value = '0;
    in_ch.t_in     = 1'b0;
    in_ch.q_in     = 1'b0;
    in_ch.m_in     = 1'b0;
    out_ch.ready   = 1'b0;
    instrs_queued  = 0;
    instrs_taken   = 0;
    mismatches     = 0;
    stuck_cycles   = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    in_taken       = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_directed();
    drain();

    // each phase ends with the sender held off until every result is back
    idle_pct = 0;  stall_pct = 0;  queue_random(PHASE_ITEMS); drain();
    idle_pct = 86; stall_pct = 0;  queue_random(PHASE_ITEMS); drain();
    idle_pct = 0;  stall_pct = 86; queue_random(PHASE_ITEMS); drain();
    idle_pct = 31; stall_pct = 31; queue_random(PHASE_ITEMS); drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### cpu_alu_compare_divstep_multiply_unit.f
hdl/alu3_pkg.sv
hdl/alu3_if.sv
hdl/alu3_exec.sv
hdl/cpu_alu_compare_divstep_multiply_unit.sv
bench/tb_cpu_alu_compare_divstep_multiply_unit.sv
